// ===== sv/i2cram_pkg.sv =====
// Shared types and constants for the I2C register access master.
// No dependencies; used by the front queue, the bus sequencer and the top level.
package i2cram_pkg;

    localparam logic [6:0]  DEV_ADDR_RESET    = 7'd104;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PHASE_TICKS    = 1'b1;

    // Bus sequence states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START1 = 9'b000000010,
        ST_TXAW   = 9'b000000100,
        ST_TXREG  = 9'b000001000,
        ST_TXDATA = 9'b000010000,
        ST_START2 = 9'b000100000,
        ST_TXAR   = 9'b001000000,
        ST_RX     = 9'b010000000,
        ST_STOP   = 9'b100000000
    } seq_t;

    // One input transaction: a clock tick with its request and pin sample.
    typedef struct packed {
        logic       request;
        logic       mode;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // One result transaction: pin drive and status after the tick.
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack_error;
    } result_t;

    // Complete sequencer state.
    typedef struct packed {
        seq_t        seq;
        logic [15:0] phase_count;
        logic [1:0]  step;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic        lmode;
        logic [7:0]  lreg;
        logic [7:0]  ldata;
        logic [7:0]  rx_byte;
        logic        error_flag;
        logic        scl_line;
        logic        sda_line;
    } seq_state_t;

endpackage

// ===== sv/i2c_register_access_master.sv =====
// Top level of the I2C register access master: configuration registers,
// front queue and bus sequencer. Depends on i2cram_pkg, i2cram_front and i2cram_seq.
//
// Each input transaction is one clock tick of an I2C bus sequencer: it carries
// a request strobe with the access to perform (mode 0 writes write_data to
// reg_address, mode 1 reads reg_address) and the sampled SDA level. Each input
// transaction yields exactly one result transaction, holding the open-drain
// release levels for SCL and SDA after that tick, the busy and done status,
// the last byte read and the NACK flag of the current or last access. A request
// arriving while an access is in progress is ignored. The block sustains one
// transaction per cycle while m_ready lets results leave: a two-entry queue
// takes the input, the sequencer steps one tick per cycle from the queue
// head when the result can move, and an output register holds the result;
// a transaction passes the queue, then that register. Every bus phase lasts
// phase_ticks ticks (zero counts as one). Configuration writes take effect
// immediately and should be made while the bus is idle; register 0 is the
// seven-bit device address, register 1 the phase length.
module i2c_register_access_master (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input tick channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_request,
    input  logic        s_mode,
    input  logic [7:0]  s_reg_address,
    input  logic [7:0]  s_write_data,
    input  logic        s_sda_in,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_release,
    output logic        m_sda_release,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_read_data,
    output logic        m_nack_error
);

    logic [6:0]  device_address_reg;
    logic [15:0] phase_ticks_reg;

    i2cram_pkg::item_t   s_item;
    i2cram_pkg::item_t   q_item;
    i2cram_pkg::result_t m_result;
    logic                q_valid;
    logic                q_pop;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= i2cram_pkg::DEV_ADDR_RESET;
            phase_ticks_reg    <= i2cram_pkg::PHASE_TICKS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                i2cram_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_wdata[6:0];
                i2cram_pkg::CFG_PHASE_TICKS:    phase_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_item = '{request: s_request, mode: s_mode, reg_address: s_reg_address,
                      write_data: s_write_data, sda_in: s_sda_in};

    i2cram_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    i2cram_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (device_address_reg),
        .phase_ticks    (phase_ticks_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result       (m_result)
    );

    assign m_scl_release = m_result.scl_release;
    assign m_sda_release = m_result.sda_release;
    assign m_busy_res    = m_result.busy_res;
    assign m_done_res    = m_result.done_res;
    assign m_read_data   = m_result.read_data;
    assign m_nack_error  = m_result.nack_error;

    // A transaction that ends is never reported as still busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done reported while busy");

    // With no access in progress both bus lines are released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> (m_scl_release && m_sda_release))
        else $error("bus line driven while idle");

    // The input side only stalls when the queue holds transactions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("input stalled with an empty queue");

    // Sequencer advances only on a queue-head pop, and each pop yields a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("popped transaction produced no result");

endmodule

// ===== sv/i2cram_front.sv =====
// Front end of the I2C register access master: accepts tick transactions
// into a two-entry queue. Depends on i2cram_pkg.
module i2cram_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  i2cram_pkg::item_t   s_item,
    output logic                q_valid,
    output i2cram_pkg::item_t   q_item,
    input  logic                q_pop
);

    i2cram_pkg::item_t mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// ===== sv/i2cram_seq.sv =====
// Back end of the I2C register access master: the bus phase sequencer and
// the result output register. Depends on i2cram_pkg.
module i2cram_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [6:0]            device_address,
    input  logic [15:0]           phase_ticks,
    input  logic                  q_valid,
    input  i2cram_pkg::item_t     q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2cram_pkg::result_t   m_result
);

    // Pin actions taken on the entry tick of a phase.
    function automatic i2cram_pkg::seq_state_t act(input i2cram_pkg::seq_state_t st,
                                                    input logic sda_in);
        i2cram_pkg::seq_state_t r;
        r = st;
        case (st.seq)
            i2cram_pkg::ST_START1, i2cram_pkg::ST_START2: begin
                case (st.step)
                    2'd0:    r.scl_line = 1'b1;
                    2'd1:    r.sda_line = 1'b1;
                    2'd2:    r.sda_line = 1'b0;
                    default: r.scl_line = 1'b0;
                endcase
            end
            i2cram_pkg::ST_TXAW, i2cram_pkg::ST_TXREG,
            i2cram_pkg::ST_TXDATA, i2cram_pkg::ST_TXAR: begin
                if (st.bit_count < 4'd8) begin
                    case (st.step)
                        2'd0:    r.sda_line = st.shift_byte[7];
                        2'd1:    r.scl_line = 1'b1;
                        2'd2:    r.scl_line = 1'b0;
                        default: r.shift_byte = {st.shift_byte[6:0], 1'b0};
                    endcase
                end else begin
                    // Acknowledge bit from the slave.
                    case (st.step)
                        2'd0:    r.sda_line = 1'b1;
                        2'd1:    r.scl_line = 1'b1;
                        2'd2:    r.error_flag = st.error_flag | sda_in;
                        default: r.scl_line = 1'b0;
                    endcase
                end
            end
            i2cram_pkg::ST_RX: begin
                if (st.bit_count == 4'd0) begin
                    r.sda_line = 1'b1;
                end else if (st.bit_count <= 4'd8) begin
                    case (st.step)
                        2'd0:    r.scl_line = 1'b1;
                        2'd1:    r.shift_byte = {st.shift_byte[6:0], sda_in};
                        default: r.scl_line = 1'b0;
                    endcase
                end else begin
                    case (st.step)
                        2'd1:    r.scl_line = 1'b1;
                        2'd2:    r.scl_line = 1'b0;
                        default: ;
                    endcase
                end
            end
            i2cram_pkg::ST_STOP: begin
                case (st.step)
                    2'd0:    r.sda_line = 1'b0;
                    2'd1:    r.scl_line = 1'b1;
                    2'd2:    r.sda_line = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic i2cram_pkg::seq_state_t enter(input i2cram_pkg::seq_state_t st,
                                                      input i2cram_pkg::seq_t s,
                                                      input logic sda_in,
                                                      input logic [6:0] addr);
        i2cram_pkg::seq_state_t r;
        r = st;
        r.seq = s;
        r.bit_count = 4'd0;
        r.step = 2'd0;
        case (s)
            i2cram_pkg::ST_TXAW:   r.shift_byte = {addr, 1'b0};
            i2cram_pkg::ST_TXAR:   r.shift_byte = {addr, 1'b1};
            i2cram_pkg::ST_TXREG:  r.shift_byte = st.lreg;
            i2cram_pkg::ST_TXDATA: r.shift_byte = st.ldata;
            i2cram_pkg::ST_RX:     r.shift_byte = 8'd0;
            default: ;
        endcase
        return act(r, sda_in);
    endfunction

    function automatic i2cram_pkg::seq_state_t advance(input i2cram_pkg::seq_state_t st,
                                                        input logic sda_in,
                                                        input logic [6:0] addr);
        i2cram_pkg::seq_state_t r;
        logic [2:0] steps;
        logic [3:0] last_bit;
        r = st;
        steps = 3'd4;
        last_bit = 4'd0;
        case (st.seq)
            i2cram_pkg::ST_TXAW, i2cram_pkg::ST_TXREG,
            i2cram_pkg::ST_TXDATA, i2cram_pkg::ST_TXAR: last_bit = 4'd8;
            i2cram_pkg::ST_RX: begin
                last_bit = 4'd9;
                steps = (st.bit_count == 4'd0) ? 3'd1 : 3'd3;
            end
            default: ;
        endcase
        if (({1'b0, st.step} + 3'd1) < steps) begin
            r.step = st.step + 2'd1;
            r = act(r, sda_in);
        end else if (st.bit_count < last_bit) begin
            r.bit_count = st.bit_count + 4'd1;
            r.step = 2'd0;
            r = act(r, sda_in);
        end else begin
            case (st.seq)
                i2cram_pkg::ST_START1: r = enter(r, i2cram_pkg::ST_TXAW, sda_in, addr);
                i2cram_pkg::ST_TXAW:   r = enter(r, i2cram_pkg::ST_TXREG, sda_in, addr);
                i2cram_pkg::ST_TXREG:
                    r = enter(r, st.lmode ? i2cram_pkg::ST_START2 : i2cram_pkg::ST_TXDATA,
                              sda_in, addr);
                i2cram_pkg::ST_TXDATA: r = enter(r, i2cram_pkg::ST_STOP, sda_in, addr);
                i2cram_pkg::ST_START2: r = enter(r, i2cram_pkg::ST_TXAR, sda_in, addr);
                i2cram_pkg::ST_TXAR:   r = enter(r, i2cram_pkg::ST_RX, sda_in, addr);
                i2cram_pkg::ST_RX: begin
                    r.rx_byte = st.shift_byte;
                    r = enter(r, i2cram_pkg::ST_STOP, sda_in, addr);
                end
                default: begin
                    r.seq = i2cram_pkg::ST_IDLE;
                    r.bit_count = 4'd0;
                    r.step = 2'd0;
                    r.scl_line = 1'b1;
                    r.sda_line = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    i2cram_pkg::seq_state_t st_reg, st_next;
    i2cram_pkg::result_t    res_reg, res_next;
    logic                   m_valid_reg;
    logic [16:0]            phase_len;
    logic                   phase_end;
    logic                   done;

    assign q_pop    = q_valid && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

    assign phase_len = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
    assign phase_end = (({1'b0, st_reg.phase_count} + 17'd1) >= phase_len);

    always_comb begin
        st_next = st_reg;
        done = 1'b0;
        if (st_reg.seq == i2cram_pkg::ST_IDLE) begin
            if (q_item.request) begin
                st_next.lmode = q_item.mode;
                st_next.lreg = q_item.reg_address;
                st_next.ldata = q_item.write_data;
                st_next.error_flag = 1'b0;
                st_next.phase_count = 16'd0;
                st_next = enter(st_next, i2cram_pkg::ST_START1, q_item.sda_in,
                                device_address);
            end
        end else if (phase_end) begin
            st_next.phase_count = 16'd0;
            done = (st_reg.seq == i2cram_pkg::ST_STOP) && (st_reg.step == 2'd3);
            st_next = advance(st_next, q_item.sda_in, device_address);
        end else begin
            st_next.phase_count = st_reg.phase_count + 16'd1;
        end

        res_next.scl_release = st_next.scl_line;
        res_next.sda_release = st_next.sda_line;
        res_next.busy_res    = (st_next.seq != i2cram_pkg::ST_IDLE);
        res_next.done_res    = done;
        res_next.read_data   = st_next.rx_byte;
        res_next.nack_error  = st_next.error_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{seq: i2cram_pkg::ST_IDLE, phase_count: 16'd0, step: 2'd0,
                        bit_count: 4'd0, shift_byte: 8'd0, lmode: 1'b0, lreg: 8'd0,
                        ldata: 8'd0, rx_byte: 8'd0, error_flag: 1'b0,
                        scl_line: 1'b1, sda_line: 1'b1};
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            st_reg <= st_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
        end
    end

endmodule
